// File: hdl/plc_pkg.sv
// ---------------------------------------------------------------------------
// Colour map package
// Widths, colour bar tables and shared types of the colour map pipeline.
// ---------------------------------------------------------------------------
package plc_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int POS_FRAC_BITS  = 8;
	localparam int FULL           = 100 << POS_FRAC_BITS;
	localparam int POS_BITS       = $clog2(FULL + 1);
	localparam int NUM_BITS       = SAMPLE_BITS + POS_BITS;
	localparam int DIV_STEPS      = 4;
	localparam int DIV_STAGES     = (POS_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int COLOUR_BITS    = 8;
	localparam int PCT_BITS       = 7;
	localparam int SUM_BITS       = COLOUR_BITS + POS_BITS;
	localparam int X_BITS         = SUM_BITS - POS_FRAC_BITS;
	localparam int RECIP_SHIFT    = 16;
	localparam int RECIP_BITS     = RECIP_SHIFT + 1;
	localparam int RECIP_ONE      = 1 << RECIP_SHIFT;
	localparam int NUM_BARS       = 3;
	localparam int BAR_BITS       = $clog2(NUM_BARS);
	localparam int MAX_STOPS      = 6;
	localparam int STOP_BITS      = $clog2(MAX_STOPS);
	localparam int NUM_CHANNELS   = 3;
	localparam int CH_BITS        = $clog2(NUM_CHANNELS);
	localparam int SEL_BITS       = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = SAMPLE_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MAP_SELECT = 2'd0,
		REG_RANGE_LOW  = 2'd1,
		REG_RANGE_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [SEL_BITS-1:0] {
		MAP_HEAT  = 2'd0,
		MAP_METEO = 2'd1,
		MAP_GRAY  = 2'd2
	} map_t;

	typedef struct packed {
		logic valid;
		logic err;
	} ctl_t;

	typedef logic [NUM_CHANNELS-1:0][COLOUR_BITS-1:0] rgb_t;

	localparam int BAR_COUNT [NUM_BARS] = '{3, 6, 2};

	localparam int BAR_PCT [NUM_BARS][MAX_STOPS] = '{
		'{0, 50, 100, 0, 0, 0},
		'{0, 20, 40, 60, 80, 100},
		'{0, 100, 0, 0, 0, 0}
	};

	localparam logic [COLOUR_BITS-1:0] BAR_RGB [NUM_BARS][MAX_STOPS][NUM_CHANNELS] = '{
		'{'{22, 136, 51}, '{221, 221, 221}, '{193, 55, 59},
		  '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
		'{'{128, 0, 255}, '{0, 0, 255}, '{0, 255, 0},
		  '{255, 255, 0}, '{255, 0, 0}, '{255, 0, 0}},
		'{'{0, 0, 0}, '{255, 255, 255},
		  '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}
	};

	// Reciprocal of each segment's width in percent, scaled by RECIP_ONE.
	localparam int BAR_RECIP [NUM_BARS][MAX_STOPS-1] = '{
		'{RECIP_ONE / 50, RECIP_ONE / 50, 0, 0, 0},
		'{RECIP_ONE / 20, RECIP_ONE / 20, RECIP_ONE / 20, RECIP_ONE / 20, RECIP_ONE / 20},
		'{RECIP_ONE / 100, 0, 0, 0, 0}
	};

	// Selector code three falls back to the gray bar.
	function automatic logic [BAR_BITS-1:0] bar_index(input logic [SEL_BITS-1:0] sel);
		case (map_t'(sel))
			MAP_HEAT:  bar_index = BAR_BITS'(MAP_HEAT);
			MAP_METEO: bar_index = BAR_BITS'(MAP_METEO);
			MAP_GRAY:  bar_index = BAR_BITS'(MAP_GRAY);
			default:   bar_index = BAR_BITS'(MAP_GRAY);
		endcase
	endfunction

	function automatic logic [POS_BITS-1:0] stop_pos(input logic [BAR_BITS-1:0] bar,
			input logic [STOP_BITS-1:0] stop);
		stop_pos = POS_BITS'(BAR_PCT[bar][stop] << POS_FRAC_BITS);
	endfunction

endpackage

// File: hdl/plc_if.sv
// ---------------------------------------------------------------------------
// Colour map channels
// Valid/ready channels for the sample words and the colour words.
// ---------------------------------------------------------------------------
interface plc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [plc_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface plc_out_if;
	logic                            valid;
	logic                            ready;
	logic [plc_pkg::COLOUR_BITS-1:0] red;
	logic [plc_pkg::COLOUR_BITS-1:0] green;
	logic [plc_pkg::COLOUR_BITS-1:0] blue;
	logic                            range_error;

	modport source (output valid, output red, output green, output blue,
		output range_error, input ready);
	modport sink (input valid, input red, input green, input blue,
		input range_error, output ready);
endinterface

// File: hdl/piecewise_linear_colormap_top.sv
// ---------------------------------------------------------------------------
// Piecewise-linear colour map
// Turns a stream of signed samples into 8-bit RGB words through a colour bar.
// ---------------------------------------------------------------------------
// Samples arrive as words on sample_ch and leave as colour words on
// colour_ch; both are valid/ready channels and a word moves when valid and
// ready are high at a rising edge. Each sample is clamped to the configured
// range, scaled to a position on the bar and blended between its two
// neighbouring stops. The bar (heat, meteorological or gray) and the range
// are set through the write port, cfg_en with cfg_index and cfg_data; write
// them only while no word is in flight.
// The pipeline has ten register stages and, while the output is not
// stalled, takes one sample in every cycle. Two stages clamp and scale,
// four divide out the position (four quotient bits a stage, three in the
// last), three blend and one holds the output word. When the receiver
// holds ready low with a word waiting, the whole pipeline freezes and
// sample_ch.ready falls; nothing is lost or repeated.
// Reset clears every valid bit and returns the registers to the heat bar
// and the range from zero to the largest positive sample.
// An empty or inverted range gives the first stop's colour with
// range_error set.
// ---------------------------------------------------------------------------
module piecewise_linear_colormap_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [plc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [plc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	plc_in_if.sink                              sample_ch,
	plc_out_if.source                           colour_ch
);

	localparam int SB = plc_pkg::SAMPLE_BITS;

	logic [plc_pkg::SEL_BITS-1:0]  map_select_q;
	logic signed [SB-1:0]          range_low_q;
	logic signed [SB-1:0]          range_high_q;

	logic                          adv;
	logic [SB-1:0]                 span;
	plc_pkg::ctl_t                 ctl_s2;
	logic [plc_pkg::NUM_BITS-1:0]  num_s2;
	plc_pkg::ctl_t                 ctl_s6;
	logic [plc_pkg::POS_BITS-1:0]  pos_s6;
	plc_pkg::ctl_t                 ctl_s9;
	plc_pkg::rgb_t                 colour_s9;
	plc_pkg::rgb_t                 colour_d;
	plc_pkg::ctl_t                 ctl_s10;
	plc_pkg::rgb_t                 colour_s10;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_select_q <= plc_pkg::SEL_BITS'(plc_pkg::MAP_HEAT);
			range_low_q  <= '0;
			range_high_q <= {1'b0, {(SB-1){1'b1}}};
		end else if (cfg_en) begin
			case (plc_pkg::cfg_reg_t'(cfg_index))
				plc_pkg::REG_MAP_SELECT: map_select_q <= cfg_data[plc_pkg::SEL_BITS-1:0];
				plc_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data[SB-1:0];
				plc_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data[SB-1:0];
				default: ;
			endcase
		end
	end

	// Every stage moves together; the output register is the only one that
	// can hold a word the receiver has not taken.
	assign adv             = !ctl_s10.valid || colour_ch.ready;
	assign sample_ch.ready = adv;

	// When the range is valid the difference fits the sample width unsigned.
	assign span = SB'(range_high_q - range_low_q);

	plc_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.sample_valid (sample_ch.valid),
		.sample       (sample_ch.sample),
		.range_low    (range_low_q),
		.range_high   (range_high_q),
		.ctl_s2       (ctl_s2),
		.num_s2       (num_s2)
	);

	plc_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.span    (span),
		.ctl_in  (ctl_s2),
		.num_in  (num_s2),
		.ctl_out (ctl_s6),
		.pos_out (pos_s6)
	);

	plc_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.map_select (map_select_q),
		.ctl_in     (ctl_s6),
		.pos_in     (pos_s6),
		.ctl_s9     (ctl_s9),
		.colour     (colour_s9)
	);

	// A range error replaces the blend with the bar's first stop.
	always_comb begin
		for (int c = 0; c < plc_pkg::NUM_CHANNELS; c++) begin
			colour_d[c] = ctl_s9.err
				? plc_pkg::BAR_RGB[plc_pkg::bar_index(map_select_q)][0][c]
				: colour_s9[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s10 <= '0;
		end else if (adv) begin
			ctl_s10 <= ctl_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			colour_s10 <= colour_d;
		end
	end

	assign colour_ch.valid       = ctl_s10.valid;
	assign colour_ch.range_error = ctl_s10.err;
	assign colour_ch.red         = colour_s10[0];
	assign colour_ch.green       = colour_s10[1];
	assign colour_ch.blue        = colour_s10[2];

	// A waiting, refused word must block the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		colour_ch.valid && !colour_ch.ready |-> !sample_ch.ready)
		else $error("input taken while the output word is stalled");

	// A stall freezes the pipeline behind the output register.
	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		colour_ch.valid && !colour_ch.ready |=> $stable(ctl_s9) && $stable(ctl_s6))
		else $error("pipeline moved during a stall");

	// A new output word can only come from a pipeline advance.
	a_output_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(colour_ch.valid) |-> $past(adv))
		else $error("output word appeared without an advance");

endmodule

// File: hdl/plc_scale.sv
// ---------------------------------------------------------------------------
// Colour map front end
// Clamps the sample to the range and forms the dividend of the position.
// ---------------------------------------------------------------------------
module plc_scale (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   sample_valid,
	input  logic signed [plc_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [plc_pkg::SAMPLE_BITS-1:0] range_low,
	input  logic signed [plc_pkg::SAMPLE_BITS-1:0] range_high,
	output plc_pkg::ctl_t                          ctl_s2,
	output logic [plc_pkg::NUM_BITS-1:0]           num_s2
);

	logic signed [plc_pkg::SAMPLE_BITS-1:0] clamped;
	logic                                   err;
	logic [plc_pkg::SAMPLE_BITS-1:0]        off;
	plc_pkg::ctl_t                          ctl_s1;
	logic [plc_pkg::SAMPLE_BITS-1:0]        off_s1;

	always_comb begin
		err = (range_high <= range_low);
		if (sample > range_high) begin
			clamped = range_high;
		end else if (sample < range_low) begin
			clamped = range_low;
		end else begin
			clamped = sample;
		end
		// The offset is never above the span, so it fits as unsigned.
		off = plc_pkg::SAMPLE_BITS'(clamped - range_low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: sample_valid, err: err};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s1 <= off;
			num_s2 <= plc_pkg::NUM_BITS'(off_s1) * plc_pkg::NUM_BITS'(plc_pkg::FULL);
		end
	end

endmodule

// File: hdl/plc_divider.sv
// ---------------------------------------------------------------------------
// Colour map position divider
// Pipelined restoring division of the scaled offset by the range span.
// ---------------------------------------------------------------------------
module plc_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [plc_pkg::SAMPLE_BITS-1:0] span,
	input  plc_pkg::ctl_t                   ctl_in,
	input  logic [plc_pkg::NUM_BITS-1:0]    num_in,
	output plc_pkg::ctl_t                   ctl_out,
	output logic [plc_pkg::POS_BITS-1:0]    pos_out
);

	localparam int SB = plc_pkg::SAMPLE_BITS;
	localparam int PB = plc_pkg::POS_BITS;

	plc_pkg::ctl_t   ctl_s [plc_pkg::DIV_STAGES];
	logic [SB-1:0]   rem_s [plc_pkg::DIV_STAGES];
	logic [PB-1:0]   low_s [plc_pkg::DIV_STAGES];
	logic [PB-1:0]   quo_s [plc_pkg::DIV_STAGES];
	logic [SB-1:0]   rem_d [plc_pkg::DIV_STAGES];
	logic [PB-1:0]   low_d [plc_pkg::DIV_STAGES];
	logic [PB-1:0]   quo_d [plc_pkg::DIV_STAGES];

	// The quotient is below two to the PB, so the top part of the dividend
	// is already below the span and only PB quotient bits are developed.
	always_comb begin
		logic [SB-1:0] r;
		logic [PB-1:0] l;
		logic [PB-1:0] q;
		logic [SB:0]   t;
		for (int j = 0; j < plc_pkg::DIV_STAGES; j++) begin
			if (j == 0) begin
				r = num_in[plc_pkg::NUM_BITS-1:PB];
				l = num_in[PB-1:0];
				q = '0;
			end else begin
				r = rem_s[j-1];
				l = low_s[j-1];
				q = quo_s[j-1];
			end
			for (int i = 0; i < plc_pkg::DIV_STEPS; i++) begin
				if (j * plc_pkg::DIV_STEPS + i < PB) begin
					t = {r, l[PB-1]};
					l = {l[PB-2:0], 1'b0};
					if (t >= {1'b0, span}) begin
						r = SB'(t - {1'b0, span});
						q = {q[PB-2:0], 1'b1};
					end else begin
						r = t[SB-1:0];
						q = {q[PB-2:0], 1'b0};
					end
				end
			end
			rem_d[j] = r;
			low_d[j] = l;
			quo_d[j] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < plc_pkg::DIV_STAGES; j++) begin
				ctl_s[j] <= '0;
			end
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
			for (int j = 1; j < plc_pkg::DIV_STAGES; j++) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < plc_pkg::DIV_STAGES; j++) begin
				rem_s[j] <= rem_d[j];
				low_s[j] <= low_d[j];
				quo_s[j] <= quo_d[j];
			end
		end
	end

	assign ctl_out = ctl_s[plc_pkg::DIV_STAGES-1];
	assign pos_out = quo_s[plc_pkg::DIV_STAGES-1];

endmodule

// File: hdl/plc_interp.sv
// ---------------------------------------------------------------------------
// Colour map interpolator
// Finds the segment of the bar and blends its two stop colours.
// ---------------------------------------------------------------------------
module plc_interp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [plc_pkg::SEL_BITS-1:0]    map_select,
	input  plc_pkg::ctl_t                   ctl_in,
	input  logic [plc_pkg::POS_BITS-1:0]    pos_in,
	output plc_pkg::ctl_t                   ctl_s9,
	output plc_pkg::rgb_t                   colour
);

	localparam int PB = plc_pkg::POS_BITS;
	localparam int XB = plc_pkg::X_BITS;
	localparam int MB = plc_pkg::X_BITS + plc_pkg::RECIP_BITS;

	logic [plc_pkg::BAR_BITS-1:0]   bar;
	logic [plc_pkg::STOP_BITS-1:0]  last;
	logic [plc_pkg::STOP_BITS-1:0]  k;
	logic [plc_pkg::STOP_BITS-1:0]  km1;
	logic [PB-1:0]                  pa;
	logic [PB-1:0]                  w;
	logic [PB-1:0]                  d;
	plc_pkg::rgb_t                  ca;
	plc_pkg::rgb_t                  cb;

	plc_pkg::ctl_t                  ctl_s7;
	plc_pkg::ctl_t                  ctl_s8;
	plc_pkg::rgb_t                  ca_s7;
	plc_pkg::rgb_t                  cb_s7;
	logic [PB-1:0]                  w_s7;
	logic [PB-1:0]                  d_s7;
	logic [plc_pkg::PCT_BITS-1:0]   diff_s7;
	logic [plc_pkg::RECIP_BITS-1:0] recip_s7;
	logic [XB-1:0]                  x_s8 [plc_pkg::NUM_CHANNELS];
	logic [plc_pkg::PCT_BITS-1:0]   diff_s8;
	logic [plc_pkg::RECIP_BITS-1:0] recip_s8;
	logic [XB-1:0]                  x_s9 [plc_pkg::NUM_CHANNELS];
	plc_pkg::rgb_t                  qe_s9;
	logic [plc_pkg::PCT_BITS-1:0]   diff_s9;
	logic [XB-1:0]                  x_d [plc_pkg::NUM_CHANNELS];
	plc_pkg::rgb_t                  qe_d;

	// Segment search: the first inner stop at or above the position, else the last.
	always_comb begin
		bar  = plc_pkg::bar_index(map_select);
		last = plc_pkg::STOP_BITS'(plc_pkg::BAR_COUNT[bar] - 1);
		k    = last;
		for (int i = plc_pkg::MAX_STOPS - 2; i >= 1; i--) begin
			if (plc_pkg::STOP_BITS'(i) < last &&
					plc_pkg::stop_pos(bar, plc_pkg::STOP_BITS'(i)) >= pos_in) begin
				k = plc_pkg::STOP_BITS'(i);
			end
		end
		km1 = k - 1'b1;
		pa  = plc_pkg::stop_pos(bar, km1);
		w   = plc_pkg::stop_pos(bar, k) - pa;
		d   = (pos_in > pa) ? pos_in - pa : '0;
		if (d > w) begin
			d = w;
		end
		for (int c = 0; c < plc_pkg::NUM_CHANNELS; c++) begin
			ca[c] = plc_pkg::BAR_RGB[bar][km1][c];
			cb[c] = plc_pkg::BAR_RGB[bar][k][c];
		end
	end

	// The blend divides by the segment width, which is its percent width
	// times a power of two: a shift, then a reciprocal multiply and one
	// correction step.
	always_comb begin
		logic [plc_pkg::SUM_BITS-1:0] sum;
		logic [MB-1:0]                prod;
		for (int c = 0; c < plc_pkg::NUM_CHANNELS; c++) begin
			sum = plc_pkg::SUM_BITS'(ca_s7[c]) * plc_pkg::SUM_BITS'(w_s7 - d_s7)
				+ plc_pkg::SUM_BITS'(cb_s7[c]) * plc_pkg::SUM_BITS'(d_s7);
			x_d[c] = sum[plc_pkg::POS_FRAC_BITS +: XB];
			prod = MB'(x_s8[c]) * MB'(recip_s8);
			qe_d[c] = prod[plc_pkg::RECIP_SHIFT +: plc_pkg::COLOUR_BITS];
		end
	end

	always_comb begin
		logic [XB-1:0] rest;
		for (int c = 0; c < plc_pkg::NUM_CHANNELS; c++) begin
			rest = x_s9[c] - XB'(qe_s9[c]) * XB'(diff_s9);
			colour[c] = (rest >= XB'(diff_s9)) ? qe_s9[c] + 1'b1 : qe_s9[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (adv) begin
			ctl_s7 <= ctl_in;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ca_s7    <= ca;
			cb_s7    <= cb;
			w_s7     <= w;
			d_s7     <= d;
			diff_s7  <= plc_pkg::PCT_BITS'(plc_pkg::BAR_PCT[bar][k] - plc_pkg::BAR_PCT[bar][km1]);
			recip_s7 <= plc_pkg::RECIP_BITS'(plc_pkg::BAR_RECIP[bar][km1]);
			x_s8     <= x_d;
			diff_s8  <= diff_s7;
			recip_s8 <= recip_s7;
			x_s9     <= x_s8;
			qe_s9    <= qe_d;
			diff_s9  <= diff_s8;
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Colour map testbench
// Streams signed samples into the piecewise-linear colour map and checks
// every colour word against an exact integer prediction of the colour bar.
// ---------------------------------------------------------------------------
module testbench;

	// Ten register stages between a sample being taken and its colour word.
	localparam int PIPE_DEPTH   = 10;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 153;
	localparam int REPORT_LIMIT = 10;
	localparam int SB           = plc_pkg::SAMPLE_BITS;
	localparam int SELB         = plc_pkg::SEL_BITS;
	localparam int CDB          = plc_pkg::CFG_DATA_BITS;
	// Position scale: 100 percent in steps of 1/256 percent.
	localparam int POS_ONE      = 1 << plc_pkg::POS_FRAC_BITS;
	localparam longint POS_FULL = 100 * POS_ONE;
	// The selector code with no bar of its own; it falls back to gray.
	localparam logic [SELB-1:0] MAP_SPARE = 2'd3;

	// Colour bars, written out independently of the design's tables.
	localparam int BAR_STOPS [3] = '{3, 6, 2};
	localparam int STOP_PCT [3][6] = '{
		'{0, 50, 100, 0, 0, 0},
		'{0, 20, 40, 60, 80, 100},
		'{0, 100, 0, 0, 0, 0}
	};
	localparam logic [7:0] STOP_RGB [3][6][3] = '{
		'{'{22, 136, 51}, '{221, 221, 221}, '{193, 55, 59},
		  '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
		'{'{128, 0, 255}, '{0, 0, 255}, '{0, 255, 0},
		  '{255, 255, 0}, '{255, 0, 0}, '{255, 0, 0}},
		'{'{0, 0, 0}, '{255, 255, 255},
		  '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       err;
	} colour_t;

	typedef struct {
		logic [SB-1:0] sample;
		colour_t       colour;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_en;
	logic [plc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [CDB-1:0] cfg_data;

	plc_in_if  sample_ch ();
	plc_out_if colour_ch ();

	piecewise_linear_colormap_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.colour_ch (colour_ch)
	);

	// Our own copy of the registers, matching the design's reset values.
	logic [SELB-1:0]      map_sel  = plc_pkg::MAP_HEAT;
	logic signed [SB-1:0] range_lo = '0;
	logic signed [SB-1:0] range_hi = 16'sh7FFF;

	// Colours still owed by the design, oldest first.
	pending_t pending_colours[$];

	int fail_count     = 0;
	int words_checked  = 0;
	int flagged_words  = 0;
	int settings_used  = 0;
	int cycle_count    = 0;
	int stall_left     = 0;
	bit steady_feed    = 1'b0;
	bit steady_drain   = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that never drains ends here as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("piecewise_linear_colormap_top verification failed");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Exact integer colour for one sample under the current register copy.
	// The sample is clamped, scaled to a position on the bar, placed in the
	// segment whose upper stop is the first at or above it, and blended.
	function automatic colour_t colour_of_sample(input logic signed [SB-1:0] s);
		int bar;
		int k;
		longint lo, hi, v, pos, pa, pb, w, d;
		logic [7:0] ch [3];
		colour_t c;
		bar = (map_sel == MAP_SPARE) ? int'(plc_pkg::MAP_GRAY) : int'(map_sel);
		lo = range_lo;
		hi = range_hi;
		v = s;
		if (hi <= lo) begin
			// Empty or inverted range: first stop of the bar, flagged.
			c.red = STOP_RGB[bar][0][0];
			c.green = STOP_RGB[bar][0][1];
			c.blue = STOP_RGB[bar][0][2];
			c.err = 1'b1;
			return c;
		end
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		pos = ((v - lo) * POS_FULL) / (hi - lo);
		k = 1;
		while (k + 1 < BAR_STOPS[bar] && longint'(STOP_PCT[bar][k]) * POS_ONE < pos)
			k++;
		pa = longint'(STOP_PCT[bar][k-1]) * POS_ONE;
		pb = longint'(STOP_PCT[bar][k]) * POS_ONE;
		w = pb - pa;
		d = (pos > pa) ? pos - pa : 0;
		if (d > w)
			d = w;
		for (int n = 0; n < 3; n++) begin
			ch[n] = 8'((longint'(STOP_RGB[bar][k-1][n]) * (w - d)
				+ longint'(STOP_RGB[bar][k][n]) * d) / w);
		end
		c.red = ch[0];
		c.green = ch[1];
		c.blue = ch[2];
		c.err = 1'b0;
		return c;
	endfunction

	// Random sample: mostly inside the range, some hugging its ends, and
	// the rest anywhere in the 16-bit space.
	function automatic int pick_sample();
		int lo, hi, r, v;
		lo = range_lo;
		hi = range_hi;
		r = $urandom_range(0, 99);
		if (hi > lo && r < 70)
			return lo + int'($urandom_range(0, hi - lo));
		if (r < 82) begin
			v = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 6)) - 3;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v;
		end
		return int'($urandom_range(0, 65535));
	endfunction

	// One sample word. Entered just after a rising edge; on return the word
	// has been taken and valid is left high so that the next word can
	// follow at once.
	task automatic send_sample(input int value);
		int gap;
		pending_t p;
		gap = steady_feed ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= value[SB-1:0];
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		p.sample = value[SB-1:0];
		p.colour = colour_of_sample(value[SB-1:0]);
		pending_colours = {pending_colours, p};
	endtask

	// Stop sending and wait until every colour owed has come back.
	task automatic drain_words();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_reg(input plc_pkg::cfg_reg_t idx, input logic [CDB-1:0] data);
		@(negedge clk);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			plc_pkg::REG_MAP_SELECT: map_sel = data[SELB-1:0];
			plc_pkg::REG_RANGE_LOW:  range_lo = data;
			plc_pkg::REG_RANGE_HIGH: range_hi = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	// Only ever called with the pipeline drained.
	task automatic program_colour_bar(input logic [SELB-1:0] sel, input int lo,
			input int hi);
		write_reg(plc_pkg::REG_MAP_SELECT, CDB'(sel));
		write_reg(plc_pkg::REG_RANGE_LOW, lo[SB-1:0]);
		write_reg(plc_pkg::REG_RANGE_HIGH, hi[SB-1:0]);
		settings_used++;
	endtask

	// Receiver: random back-pressure, switched off for whole phases now and
	// then so that the pipeline also runs flat out.
	initial begin
		colour_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0)
				stall_left = steady_drain ? 0 : gap_len();
			if (stall_left > 0) begin
				colour_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				colour_ch.ready <= 1'b1;
			end
		end
	end

	// Every colour word taken is compared with the oldest prediction.
	always @(posedge clk) begin
		pending_t p;
		colour_t got;
		if (arst_n && colour_ch.valid === 1'b1 && colour_ch.ready === 1'b1) begin
			got.red = colour_ch.red;
			got.green = colour_ch.green;
			got.blue = colour_ch.blue;
			got.err = colour_ch.range_error;
			if (pending_colours.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected colour word r%0d g%0d b%0d err%0d",
						got.red, got.green, got.blue, got.err);
			end else begin
				p = pending_colours.pop_front();
				words_checked++;
				if (p.colour.err)
					flagged_words++;
				if (got !== p.colour) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display({"sample %0d: expected r%0d g%0d b%0d err%0d, ",
							"got r%0d g%0d b%0d err%0d"},
							$signed(p.sample), p.colour.red, p.colour.green,
							p.colour.blue, p.colour.err, got.red, got.green,
							got.blue, got.err);
				end
			end
		end
	end

	// Reset values: heat bar over zero to the largest positive sample,
	// including clamping below the range and a hit on the middle stop.
	task automatic test_reset_defaults();
		send_sample(-32768);
		send_sample(-1);
		send_sample(0);
		send_sample(16383);
		send_sample(16384);
		send_sample(32767);
	endtask

	// The other bars and the spare selector over the widest possible range.
	task automatic test_every_bar();
		logic [SELB-1:0] sels [3];
		sels = '{plc_pkg::MAP_METEO, plc_pkg::MAP_GRAY, MAP_SPARE};
		foreach (sels[n]) begin
			drain_words();
			program_colour_bar(sels[n], -32768, 32767);
			send_sample(-32768);
			send_sample(0);
			send_sample(32767);
		end
	endtask

	// Samples landing exactly on the inner stops of the meteorological bar.
	task automatic test_stop_hits();
		drain_words();
		program_colour_bar(plc_pkg::MAP_METEO, 0, 100);
		send_sample(20);
		send_sample(40);
		send_sample(60);
		send_sample(80);
	endtask

	// Empty range and fully inverted range must raise the error flag.
	task automatic test_bad_range();
		drain_words();
		program_colour_bar(plc_pkg::MAP_HEAT, 100, 100);
		send_sample(100);
		drain_words();
		program_colour_bar(plc_pkg::MAP_METEO, 32767, -32768);
		send_sample(0);
	endtask

	// Random phases, each with its own bar and range. Narrow spans give
	// coarse interpolation, wide ones fine; some ranges are empty or
	// inverted. One phase stops halfway until the pipeline is empty.
	task automatic test_random_stream();
		int p, i, kind, lo, hi, a, b;
		logic [SELB-1:0] sel;
		for (p = 0; p < RAND_PHASES; p++) begin
			sel = (p < 4) ? SELB'(p) : SELB'($urandom_range(0, 3));
			kind = (p < 2) ? p : $urandom_range(0, 9);
			a = int'($urandom_range(0, 65535)) - 32768;
			b = int'($urandom_range(0, 65535)) - 32768;
			case (kind)
				0: begin
					lo = -32768;
					hi = 32767;
				end
				1: begin
					lo = (a == 32767) ? 32766 : a;
					hi = lo + int'($urandom_range(1, 200));
					if (hi > 32767)
						hi = 32767;
				end
				2: begin
					lo = a;
					hi = a;
				end
				3: begin
					lo = (a > b) ? a : b;
					hi = (a > b) ? b : a;
				end
				4: begin
					lo = (a == 32767) ? 32766 : a;
					hi = lo + 1;
				end
				default: begin
					lo = (a < b) ? a : b;
					hi = (a < b) ? b : a;
				end
			endcase
			drain_words();
			program_colour_bar(sel, lo, hi);
			steady_feed = (p % 4 == 2);
			steady_drain = (p % 4 == 3);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2)
					drain_words();
				send_sample(pick_sample());
			end
		end
		steady_feed = 1'b0;
		steady_drain = 1'b0;
	endtask

	initial begin
		cfg_en = 1'b0;
		cfg_index = plc_pkg::REG_MAP_SELECT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_every_bar();
		test_stop_hits();
		test_bad_range();
		test_random_stream();

		drain_words();
		if (pending_colours.size() != 0)
			fail_count++;

		$display("Checked %0d colour words under %0d register settings, all four selector codes.",
			words_checked, settings_used);
		$display("%0d of those words came from an empty or inverted range.", flagged_words);
		if (fail_count == 0)
			$display("piecewise_linear_colormap_top verification clean");
		else
			$display("piecewise_linear_colormap_top verification failed");
		$finish;
	end

endmodule

// File: piecewise_linear_colormap_top.f
hdl/plc_pkg.sv
hdl/plc_if.sv
hdl/plc_scale.sv
hdl/plc_divider.sv
hdl/plc_interp.sv
hdl/piecewise_linear_colormap_top.sv
verif/testbench.sv
